/* hw/rtl/bsmp_pkg.sv */
// shared types, constants and helper functions for the skinning matrix palette
package bsmp_pkg;

	localparam int DEF_MAX_BONES = 512;
	localparam int IN_W          = 344;
	localparam int OUT_W         = 104;
	localparam int SLOT_W        = 4;

	// per-bone slots in the store: rotation 0..8, translation 9..11, rest 12..14
	localparam logic [SLOT_W-1:0] SLOT_TRANS = 4'd9;
	localparam logic [SLOT_W-1:0] SLOT_REST  = 4'd12;
	localparam logic [SLOT_W-1:0] SLOT_LAST  = 4'd14;
	localparam logic [SLOT_W-1:0] SLOT_END   = 4'd15;

	// product sequence end indices and the first matrix translation entry
	localparam logic [3:0] QUAT_LAST = 4'd8;
	localparam logic [3:0] MAT_TRANS = 4'd9;
	localparam logic [3:0] MAT_LAST  = 4'd11;
	localparam logic [3:0] COL3_LAST = 4'd2;
	localparam logic [1:0] TERM_LAST = 2'd2;
	localparam logic [3:0] COL_LAST  = 4'd3;

	localparam logic signed [39:0] ONE_Q30 = 40'sd1073741824;

	typedef enum logic [1:0] {
		OP_QUAT,
		OP_MAT,
		OP_COL3
	} op_t;

	typedef struct packed {
		logic       load;
		logic       mul_go;
		op_t        op;
		logic       rot;
		logic       rd_par;
		logic       local_step;
		logic       wr_en;
		logic [3:0] idx;
		logic [1:0] term;
	} cmd_t;

	typedef struct packed {
		logic root;
		logic store;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] res;
		if (v > 40'sd2147483647) begin
			res = 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

	function automatic logic [1:0] row_of(input logic [3:0] e);
		logic [1:0] res;
		case (e) inside
			4'd0, 4'd1, 4'd2, 4'd9:  res = 2'd0;
			4'd3, 4'd4, 4'd5, 4'd10: res = 2'd1;
			default:                 res = 2'd2;
		endcase
		return res;
	endfunction

	function automatic logic [1:0] col_of(input logic [3:0] e);
		logic [1:0] res;
		case (e) inside
			4'd0, 4'd3, 4'd6: res = 2'd0;
			4'd1, 4'd4, 4'd7: res = 2'd1;
			default:          res = 2'd2;
		endcase
		return res;
	endfunction

	function automatic logic [3:0] idx3(input logic [1:0] i, input logic [1:0] k);
		return 4'(i) * 4'd3 + 4'(k);
	endfunction

	// quaternion products xx yy zz xy xz yz wx wy wz, components x=0 y=1 z=2 w=3
	function automatic logic [1:0] quat_a(input logic [3:0] e);
		logic [1:0] res;
		case (e) inside
			4'd0, 4'd3, 4'd4: res = 2'd0;
			4'd1, 4'd5:       res = 2'd1;
			4'd2:             res = 2'd2;
			default:          res = 2'd3;
		endcase
		return res;
	endfunction

	function automatic logic [1:0] quat_b(input logic [3:0] e);
		logic [1:0] res;
		case (e) inside
			4'd0, 4'd6:       res = 2'd0;
			4'd1, 4'd3, 4'd7: res = 2'd1;
			default:          res = 2'd2;
		endcase
		return res;
	endfunction

endpackage

/* hw/rtl/bsmp_ram.sv */
// generic single-clock ram with one write port and a registered read port
module bsmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/bsmp_ctrl.sv */
// sequencer for the skinning matrix palette
module bsmp_ctrl import bsmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_QUAT  = 9'b000000010,
		S_ROT   = 9'b000000100,
		S_RDPAR = 9'b000001000,
		S_LOCAL = 9'b000010000,
		S_MAT   = 9'b000100000,
		S_COL3  = 9'b001000000,
		S_WRITE = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t     state_q;
	logic [3:0] e_q;
	logic [1:0] k_q;
	logic       drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			e_q     <= '0;
			k_q     <= '0;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					e_q     <= '0;
					k_q     <= '0;
					drain_q <= 1'b0;
					if (s_axis_tvalid) begin
						state_q <= S_QUAT;
					end
				end
				S_QUAT: begin
					if (drain_q) begin
						drain_q <= 1'b0;
						e_q     <= '0;
						state_q <= S_ROT;
					end else if (e_q == QUAT_LAST) begin
						drain_q <= 1'b1;
					end else begin
						e_q <= e_q + 4'd1;
					end
				end
				S_ROT: begin
					state_q <= sts.root ? S_LOCAL : S_RDPAR;
				end
				S_RDPAR: begin
					if (e_q == SLOT_END) begin
						e_q     <= '0;
						state_q <= S_LOCAL;
					end else begin
						e_q <= e_q + 4'd1;
					end
				end
				S_LOCAL: begin
					state_q <= sts.root ? S_COL3 : S_MAT;
				end
				S_MAT, S_COL3: begin
					if (drain_q) begin
						drain_q <= 1'b0;
						e_q     <= '0;
						k_q     <= '0;
						if (state_q == S_MAT) begin
							state_q <= S_COL3;
						end else begin
							state_q <= sts.store ? S_WRITE : S_OUT;
						end
					end else if (k_q == TERM_LAST) begin
						k_q <= '0;
						if ((state_q == S_MAT && e_q == MAT_LAST) ||
						    (state_q == S_COL3 && e_q == COL3_LAST)) begin
							drain_q <= 1'b1;
						end else begin
							e_q <= e_q + 4'd1;
						end
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_WRITE: begin
					if (e_q == SLOT_LAST) begin
						e_q     <= '0;
						state_q <= S_OUT;
					end else begin
						e_q <= e_q + 4'd1;
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						if (e_q == COL_LAST) begin
							e_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							e_q <= e_q + 4'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && s_axis_tvalid;
		cmd.mul_go     = (state_q == S_QUAT || state_q == S_MAT || state_q == S_COL3) &&
		                 !drain_q;
		cmd.op         = (state_q == S_QUAT) ? OP_QUAT :
		                 (state_q == S_MAT) ? OP_MAT : OP_COL3;
		cmd.rot        = (state_q == S_ROT);
		cmd.rd_par     = (state_q == S_RDPAR);
		cmd.local_step = (state_q == S_LOCAL);
		cmd.wr_en      = (state_q == S_WRITE);
		cmd.idx        = e_q;
		cmd.term       = k_q;
	end

endmodule

/* hw/rtl/bsmp_datapath.sv */
// operand registers, shared multiply-accumulate and transform store
module bsmp_datapath import bsmp_pkg::*; #(
	parameter int MAX_BONES = DEF_MAX_BONES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	input  logic [IN_W-1:0]  in_data,
	output sts_t             sts,
	output logic [OUT_W-1:0] out_data,
	output logic             out_last,
	output logic             out_fault
);

	localparam int BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam int AW    = BW + SLOT_W;
	localparam int DEPTH = MAX_BONES * (2 ** SLOT_W);

	logic        [8:0]  bone_q;
	logic        [9:0]  par_q;
	logic signed [31:0] rest_q [3];
	logic signed [31:0] move_q [3];
	logic signed [31:0] q_q [4];
	logic signed [35:0] term_q [9];
	logic signed [31:0] r_q [9];
	logic signed [31:0] wr_q [9];
	logic signed [31:0] wt_q [3];
	logic signed [31:0] lt_q [3];
	logic signed [31:0] pr_q [9];
	logic signed [31:0] pt_q [3];
	logic signed [31:0] pp_q [3];
	logic signed [31:0] col3_q [3];
	logic signed [39:0] acc_q;

	logic signed [64:0] prod_s1;
	logic               mul_v_s1;
	op_t                op_s1;
	logic        [3:0]  e_s1;
	logic        [1:0]  k_s1;
	logic               rd_v_s1;
	logic        [3:0]  rd_idx_s1;

	logic        [8:0]  par9;
	logic               fault;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [64:0] prod_rnd;
	logic signed [35:0] t;
	logic signed [39:0] base;
	logic signed [39:0] sum;
	logic        [3:0]  ex;
	logic        [3:0]  wx;
	logic        [3:0]  rx;
	logic        [31:0] ram_wdata;
	logic        [31:0] ram_rdata;
	logic        [1:0]  col;

	assign par9      = par_q[8:0];
	assign fault     = !par_q[9] && ((par9 >= bone_q) || (32'(par9) >= MAX_BONES));
	assign sts.root  = par_q[9] || fault;
	assign sts.store = 32'(bone_q) < MAX_BONES;
	assign rx        = rd_idx_s1 - SLOT_TRANS;

	// input capture and parent word capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bone_q    <= in_data[8:0];
			par_q     <= in_data[18:9];
			rest_q[0] <= in_data[50:19];
			rest_q[1] <= in_data[82:51];
			rest_q[2] <= in_data[114:83];
			q_q[0]    <= in_data[146:115];
			q_q[1]    <= in_data[178:147];
			q_q[2]    <= in_data[210:179];
			q_q[3]    <= in_data[242:211];
			move_q[0] <= in_data[274:243];
			move_q[1] <= in_data[306:275];
			move_q[2] <= in_data[338:307];
		end
		if (rd_v_s1) begin
			if (rd_idx_s1 < SLOT_TRANS) begin
				pr_q[rd_idx_s1] <= ram_rdata;
			end else if (rd_idx_s1 < SLOT_REST) begin
				pt_q[rx[1:0]] <= ram_rdata;
			end else if (rd_idx_s1 <= SLOT_LAST) begin
				pp_q[rx[1:0] - 2'd3] <= ram_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			mul_v_s1 <= 1'b0;
		end else begin
			rd_v_s1  <= cmd.rd_par;
			mul_v_s1 <= cmd.mul_go;
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_QUAT: begin
				mul_a = q_q[quat_a(cmd.idx)];
				mul_b = 33'(q_q[quat_b(cmd.idx)]);
			end
			OP_MAT: begin
				mul_a = pr_q[idx3(row_of(cmd.idx), cmd.term)];
				if (cmd.idx < MAT_TRANS) begin
					mul_b = 33'(r_q[idx3(cmd.term, col_of(cmd.idx))]);
				end else begin
					mul_b = 33'(lt_q[cmd.term]);
				end
			end
			default: begin
				mul_a = wr_q[idx3(cmd.idx[1:0], cmd.term)];
				mul_b = -33'(rest_q[cmd.term]);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		op_s1   <= cmd.op;
		e_s1    <= cmd.idx;
		k_s1    <= cmd.term;
		rd_idx_s1 <= cmd.idx;
	end

	// rounding and accumulate
	always_comb begin
		ex = e_s1 - MAT_TRANS;
		if (op_s1 == OP_QUAT) begin
			prod_rnd = prod_s1 + (65'sd1 <<< 28);
			t        = 36'(prod_rnd >>> 29);
		end else begin
			prod_rnd = prod_s1 + (65'sd1 <<< 29);
			t        = 36'(prod_rnd >>> 30);
		end
		if (k_s1 != 2'd0) begin
			base = acc_q;
		end else if (op_s1 == OP_MAT && e_s1 >= MAT_TRANS) begin
			base = 40'(pt_q[ex[1:0]]);
		end else if (op_s1 == OP_COL3) begin
			base = 40'(wt_q[e_s1[1:0]]);
		end else begin
			base = '0;
		end
		sum = base + 40'(t);
	end

	always_ff @(posedge clk) begin
		if (mul_v_s1) begin
			if (op_s1 == OP_QUAT) begin
				term_q[e_s1] <= t;
			end else if (k_s1 != TERM_LAST) begin
				acc_q <= sum;
			end else if (op_s1 == OP_MAT) begin
				if (e_s1 < MAT_TRANS) begin
					wr_q[e_s1] <= sat32(sum);
				end else begin
					wt_q[ex[1:0]] <= sat32(sum);
				end
			end else begin
				col3_q[e_s1[1:0]] <= sat32(sum);
			end
		end
		if (cmd.rot) begin
			r_q[0] <= sat32(ONE_Q30 - (40'(term_q[1]) + 40'(term_q[2])));
			r_q[1] <= sat32(40'(term_q[3]) - 40'(term_q[8]));
			r_q[2] <= sat32(40'(term_q[4]) + 40'(term_q[7]));
			r_q[3] <= sat32(40'(term_q[3]) + 40'(term_q[8]));
			r_q[4] <= sat32(ONE_Q30 - (40'(term_q[0]) + 40'(term_q[2])));
			r_q[5] <= sat32(40'(term_q[5]) - 40'(term_q[6]));
			r_q[6] <= sat32(40'(term_q[4]) - 40'(term_q[7]));
			r_q[7] <= sat32(40'(term_q[5]) + 40'(term_q[6]));
			r_q[8] <= sat32(ONE_Q30 - (40'(term_q[0]) + 40'(term_q[1])));
		end
		if (cmd.local_step) begin
			for (int i = 0; i < 3; i++) begin
				if (sts.root) begin
					wt_q[i] <= sat32(40'(rest_q[i]) + 40'(move_q[i]));
				end else begin
					lt_q[i] <= sat32(40'(rest_q[i]) - 40'(pp_q[i]) + 40'(move_q[i]));
				end
			end
			if (sts.root) begin
				for (int i = 0; i < 9; i++) begin
					wr_q[i] <= r_q[i];
				end
			end
		end
	end

	// store write data
	always_comb begin
		wx = cmd.idx - SLOT_TRANS;
		if (cmd.idx < SLOT_TRANS) begin
			ram_wdata = wr_q[cmd.idx];
		end else if (cmd.idx < SLOT_REST) begin
			ram_wdata = wt_q[wx[1:0]];
		end else begin
			ram_wdata = rest_q[wx[1:0] - 2'd3];
		end
	end

	bsmp_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en && sts.store),
		.waddr({BW'(bone_q), cmd.idx}),
		.wdata(ram_wdata),
		.raddr({BW'(par9), cmd.idx}),
		.rdata(ram_rdata)
	);

	// result word
	assign col = cmd.idx[1:0];
	always_comb begin
		out_data = '0;
		out_data[1:0] = col;
		if (col == 2'd3) begin
			out_data[33:2]  = col3_q[0];
			out_data[65:34] = col3_q[1];
			out_data[97:66] = col3_q[2];
		end else begin
			out_data[33:2]  = wr_q[idx3(2'd0, col)];
			out_data[65:34] = wr_q[idx3(2'd1, col)];
			out_data[97:66] = wr_q[idx3(2'd2, col)];
		end
	end
	assign out_last  = (col == 2'd3);
	assign out_fault = fault;

endmodule

/* hw/rtl/bone_skinning_matrix_palette.sv */
// top level of the bone skinning matrix palette
// Takes one bone word at a time (parents first) and returns four column words of
// world times inverse bind. A child bone reads the 15 words of its parent from the
// store and a bone within the store writes its own 15 words; a bone beyond the
// store skips the writes. The work is done by the one shared 32x33 multiplier
// (9 quaternion, 36 matrix and 9 column products, one per cycle) and the store's
// separate read and write ports. A new bone is taken only after all four columns
// have left. The transform store is not cleared after reset.
module bone_skinning_matrix_palette import bsmp_pkg::*; #(
	parameter int MAX_BONES = DEF_MAX_BONES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// bone_number, parent_number, rest_x/y/z, quat_x/y/z/w, move_x/y/z
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// column_number, entry_row0, entry_row1, entry_row2
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic             m_axis_tlast,
	// parent_fault
	output logic             m_axis_tuser
);

	cmd_t cmd;
	sts_t sts;

	bsmp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.sts          (sts),
		.cmd          (cmd)
	);

	bsmp_datapath #(
		.MAX_BONES(MAX_BONES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.sts      (sts),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast),
		.out_fault(m_axis_tuser)
	);

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while results pending");

	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[1:0] == 2'd3)
		else $error("last flag on wrong column");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after accept");
`endif

endmodule
